// File: rtl/c8alu_pkg.sv
// Package: operation codes, branch conditions and status bit positions for the CPU8 execute stage.
package c8alu_pkg;

  typedef enum logic [4:0] {
    ACT_ORA    = 5'd0,
    ACT_AND    = 5'd1,
    ACT_EOR    = 5'd2,
    ACT_ADC    = 5'd3,
    ACT_SBC    = 5'd4,
    ACT_LDA    = 5'd5,
    ACT_CMP    = 5'd6,
    ACT_BIT    = 5'd7,
    ACT_INX    = 5'd8,
    ACT_INY    = 5'd9,
    ACT_DEX    = 5'd10,
    ACT_DEY    = 5'd11,
    ACT_TAX    = 5'd12,
    ACT_TXA    = 5'd13,
    ACT_TAY    = 5'd14,
    ACT_TYA    = 5'd15,
    ACT_TSX    = 5'd16,
    ACT_TXS    = 5'd17,
    ACT_SEC    = 5'd18,
    ACT_CLC    = 5'd19,
    ACT_SED    = 5'd20,
    ACT_CLD    = 5'd21,
    ACT_SEI    = 5'd22,
    ACT_CLI    = 5'd23,
    ACT_CLV    = 5'd24,
    ACT_BRANCH = 5'd25
  } act_t;

  typedef enum logic [2:0] {
    BR_CC = 3'd0,
    BR_CS = 3'd1,
    BR_EQ = 3'd2,
    BR_MI = 3'd3,
    BR_NE = 3'd4,
    BR_PL = 3'd5,
    BR_VC = 3'd6,
    BR_VS = 3'd7
  } br_cond_t;

  localparam int unsigned FLG_N = 7;
  localparam int unsigned FLG_V = 6;
  localparam int unsigned FLG_D = 3;
  localparam int unsigned FLG_I = 2;
  localparam int unsigned FLG_Z = 1;
  localparam int unsigned FLG_C = 0;

  localparam logic [7:0] SIGN_MASK = 8'h80;
  localparam logic [7:0] SP_RESET  = 8'hFF;

endpackage

// File: rtl/c8alu_if.sv
// Interfaces: request and result channels of the CPU8 execute stage.
interface c8alu_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] action;
  logic [7:0] operand;
  logic [2:0] branch_cond;

  modport source (output valid, action, operand, branch_cond, input ready);
  modport sink   (input valid, action, operand, branch_cond, output ready);
endinterface

interface c8alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] sp_out;
  logic [7:0] status_out;
  logic       branch_taken;

  modport source (output valid, acc_out, x_out, y_out, sp_out, status_out, branch_taken,
                  input ready);
  modport sink   (input valid, acc_out, x_out, y_out, sp_out, status_out, branch_taken,
                  output ready);
endinterface

// File: rtl/cpu8_alu_register_execute.sv
// Top level: register file, ALU and status flags of the CPU8 execute stage.
// A request is held in the input register, then executes into the result register.
// Throughput: one request per cycle while the output is not stalled; the two registers are
// separate stages, so an empty input register takes a new request while a result waits.
// The result register is the architectural register set, updated when a request executes.
// Reset (synchronous, rst_n low): A, X, Y, status cleared, SP = 0xFF, both stages empty.
module cpu8_alu_register_execute
  import c8alu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  c8alu_in_if.sink           in_chan,
  c8alu_out_if.source        out_chan
);

  // input register
  logic       in_valid_r;
  act_t       act_r;
  logic [7:0] opnd_r;
  br_cond_t   cond_r;

  // architectural registers, shown directly as the result
  logic       out_valid_r;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic [7:0] status_r, status_nxt;
  logic       taken_r, taken_nxt;

  logic       advance;
  logic       in_ready;
  logic [7:0] m_eff;
  logic [8:0] sum9;
  logic [8:0] diff9;
  logic [7:0] nz_val;
  logic       nz_upd;

  assign advance  = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || advance;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_ready && in_chan.valid) begin
      act_r  <= act_t'(in_chan.action);
      opnd_r <= in_chan.operand;
      cond_r <= br_cond_t'(in_chan.branch_cond);
    end
  end

  // SBC runs through the same adder with the operand inverted
  assign m_eff = (act_r == ACT_SBC) ? ~opnd_r : opnd_r;
  assign sum9  = {1'b0, acc_r} + {1'b0, m_eff} + {8'd0, status_r[FLG_C]};
  assign diff9 = {1'b0, acc_r} - {1'b0, opnd_r};

  always_comb begin
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    sp_nxt     = sp_r;
    status_nxt = status_r;
    taken_nxt  = 1'b0;
    nz_val     = 8'd0;
    nz_upd     = 1'b0;
    unique case (act_r)
      ACT_ORA: begin acc_nxt = acc_r | opnd_r; nz_val = acc_nxt; nz_upd = 1'b1; end
      ACT_AND: begin acc_nxt = acc_r & opnd_r; nz_val = acc_nxt; nz_upd = 1'b1; end
      ACT_EOR: begin acc_nxt = acc_r ^ opnd_r; nz_val = acc_nxt; nz_upd = 1'b1; end
      ACT_ADC, ACT_SBC: begin
        acc_nxt           = sum9[7:0];
        status_nxt[FLG_C] = sum9[8];
        status_nxt[FLG_V] = |((acc_r ^ sum9[7:0]) & (m_eff ^ sum9[7:0]) & SIGN_MASK);
        nz_val            = sum9[7:0];
        nz_upd            = 1'b1;
      end
      ACT_LDA: begin acc_nxt = opnd_r; nz_val = opnd_r; nz_upd = 1'b1; end
      ACT_CMP: begin
        status_nxt[FLG_C] = !diff9[8];
        nz_val            = diff9[7:0];
        nz_upd            = 1'b1;
      end
      ACT_BIT: begin
        status_nxt[FLG_Z] = ((acc_r & opnd_r) == 8'd0);
        status_nxt[FLG_N] = opnd_r[7];
        status_nxt[FLG_V] = opnd_r[6];
      end
      ACT_INX: begin x_nxt = x_r + 8'd1; nz_val = x_nxt; nz_upd = 1'b1; end
      ACT_INY: begin y_nxt = y_r + 8'd1; nz_val = y_nxt; nz_upd = 1'b1; end
      ACT_DEX: begin x_nxt = x_r - 8'd1; nz_val = x_nxt; nz_upd = 1'b1; end
      ACT_DEY: begin y_nxt = y_r - 8'd1; nz_val = y_nxt; nz_upd = 1'b1; end
      ACT_TAX: begin x_nxt = acc_r; nz_val = acc_r; nz_upd = 1'b1; end
      ACT_TXA: begin acc_nxt = x_r; nz_val = x_r; nz_upd = 1'b1; end
      ACT_TAY: begin y_nxt = acc_r; nz_val = acc_r; nz_upd = 1'b1; end
      ACT_TYA: begin acc_nxt = y_r; nz_val = y_r; nz_upd = 1'b1; end
      ACT_TSX: begin x_nxt = sp_r; nz_val = sp_r; nz_upd = 1'b1; end
      ACT_TXS: sp_nxt = x_r;
      ACT_SEC: status_nxt[FLG_C] = 1'b1;
      ACT_CLC: status_nxt[FLG_C] = 1'b0;
      ACT_SED: status_nxt[FLG_D] = 1'b1;
      ACT_CLD: status_nxt[FLG_D] = 1'b0;
      ACT_SEI: status_nxt[FLG_I] = 1'b1;
      ACT_CLI: status_nxt[FLG_I] = 1'b0;
      ACT_CLV: status_nxt[FLG_V] = 1'b0;
      ACT_BRANCH: begin
        case (cond_r)
          BR_CC:   taken_nxt = !status_r[FLG_C];
          BR_CS:   taken_nxt = status_r[FLG_C];
          BR_EQ:   taken_nxt = status_r[FLG_Z];
          BR_MI:   taken_nxt = status_r[FLG_N];
          BR_NE:   taken_nxt = !status_r[FLG_Z];
          BR_PL:   taken_nxt = !status_r[FLG_N];
          BR_VC:   taken_nxt = !status_r[FLG_V];
          default: taken_nxt = status_r[FLG_V];
        endcase
      end
      default: ; // unassigned codes leave everything as is
    endcase
    if (nz_upd) begin
      status_nxt[FLG_N] = nz_val[7];
      status_nxt[FLG_Z] = (nz_val == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= 8'd0;
      x_r         <= 8'd0;
      y_r         <= 8'd0;
      sp_r        <= SP_RESET;
      status_r    <= 8'd0;
      taken_r     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        x_r         <= x_nxt;
        y_r         <= y_nxt;
        sp_r        <= sp_nxt;
        status_r    <= status_nxt;
        taken_r     <= taken_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.acc_out      = acc_r;
  assign out_chan.x_out        = x_r;
  assign out_chan.y_out        = y_r;
  assign out_chan.sp_out       = sp_r;
  assign out_chan.status_out   = status_r;
  assign out_chan.branch_taken = taken_r;

`ifndef SYNTHESIS
  a_txs_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    advance && act_r == ACT_TXS |=> status_r == $past(status_r))
    else $error("TXS changed the status register");

  a_unused_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[5:4] == 2'b00)
    else $error("status bits 5 and 4 not zero");

  a_taken_only_branch: assert property (@(posedge clk) disable iff (!rst_n)
    advance && act_r != ACT_BRANCH |=> !taken_r)
    else $error("branch_taken set by a non-branch request");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> $stable(acc_r) && $stable(status_r) && $stable(sp_r))
    else $error("register set changed while a result was stalled");

  a_full_input_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |-> !in_ready)
    else $error("request taken while the input register was held");
`endif

endmodule

// File: tb/sv/tb_cpu8_alu_register_execute.sv
`timescale 1ns / 100ps
// Testbench: random and directed requests into the CPU8 execute stage with a register predictor.
import c8alu_pkg::*;

typedef struct packed {
  logic [7:0] acc;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] sp;
  logic [7:0] status;
  logic       taken;
} reg_snapshot_t;

class cpu8_state_tracker;
  logic [7:0]    acc;
  logic [7:0]    x;
  logic [7:0]    y;
  logic [7:0]    sp;
  logic [7:0]    status;
  reg_snapshot_t expected_regs[$];
  int            mismatches;

  function new();
    acc = 8'h00;
    x = 8'h00;
    y = 8'h00;
    sp = SP_RESET;
    status = 8'h00;
    mismatches = 0;
  endfunction

  function void set_nz(logic [7:0] v);
    status[FLG_N] = v[7];
    status[FLG_Z] = (v == 8'h00);
  endfunction

  // Apply one accepted request to the tracked registers and queue the snapshot.
  function void note_request(logic [4:0] act, logic [7:0] m, logic [2:0] cond);
    reg_snapshot_t snap;
    logic [8:0]    sum;
    logic [7:0]    addend;
    logic          taken;
    taken = 1'b0;
    case (act)
      ACT_ORA: begin acc = acc | m; set_nz(acc); end
      ACT_AND: begin acc = acc & m; set_nz(acc); end
      ACT_EOR: begin acc = acc ^ m; set_nz(acc); end
      ACT_ADC, ACT_SBC: begin
        addend = (act == ACT_SBC) ? ~m : m;
        sum = {1'b0, acc} + {1'b0, addend} + {8'h00, status[FLG_C]};
        status[FLG_C] = sum[8];
        status[FLG_V] = ((acc ^ sum[7:0]) & (addend ^ sum[7:0]) & SIGN_MASK) != 8'h00;
        acc = sum[7:0];
        set_nz(acc);
      end
      ACT_LDA: begin acc = m; set_nz(acc); end
      ACT_CMP: begin
        status[FLG_C] = (acc >= m);
        set_nz(acc - m);
      end
      ACT_BIT: begin
        status[FLG_Z] = ((acc & m) == 8'h00);
        status[FLG_N] = m[7];
        status[FLG_V] = m[6];
      end
      ACT_INX: begin x = x + 8'd1; set_nz(x); end
      ACT_INY: begin y = y + 8'd1; set_nz(y); end
      ACT_DEX: begin x = x - 8'd1; set_nz(x); end
      ACT_DEY: begin y = y - 8'd1; set_nz(y); end
      ACT_TAX: begin x = acc; set_nz(x); end
      ACT_TXA: begin acc = x; set_nz(acc); end
      ACT_TAY: begin y = acc; set_nz(y); end
      ACT_TYA: begin acc = y; set_nz(acc); end
      ACT_TSX: begin x = sp; set_nz(x); end
      ACT_TXS: sp = x;
      ACT_SEC: status[FLG_C] = 1'b1;
      ACT_CLC: status[FLG_C] = 1'b0;
      ACT_SED: status[FLG_D] = 1'b1;
      ACT_CLD: status[FLG_D] = 1'b0;
      ACT_SEI: status[FLG_I] = 1'b1;
      ACT_CLI: status[FLG_I] = 1'b0;
      ACT_CLV: status[FLG_V] = 1'b0;
      ACT_BRANCH: begin
        case (cond)
          BR_CC: taken = !status[FLG_C];
          BR_CS: taken = status[FLG_C];
          BR_EQ: taken = status[FLG_Z];
          BR_MI: taken = status[FLG_N];
          BR_NE: taken = !status[FLG_Z];
          BR_PL: taken = !status[FLG_N];
          BR_VC: taken = !status[FLG_V];
          default: taken = status[FLG_V];
        endcase
      end
      default: ;  // undefined codes leave everything alone
    endcase
    snap.acc = acc;
    snap.x = x;
    snap.y = y;
    snap.sp = sp;
    snap.status = status;
    snap.taken = taken;
    expected_regs.push_back(snap);
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("error at %0t: %s", $realtime, msg);
  endtask

  task check_result(reg_snapshot_t got);
    reg_snapshot_t want;
    if (expected_regs.size() == 0) begin
      report("result with no request pending");
    end else begin
      want = expected_regs.pop_front();
      if (got.acc !== want.acc)
        report($sformatf("acc_out got %h want %h", got.acc, want.acc));
      if (got.x !== want.x)
        report($sformatf("x_out got %h want %h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("y_out got %h want %h", got.y, want.y));
      if (got.sp !== want.sp)
        report($sformatf("sp_out got %h want %h", got.sp, want.sp));
      if (got.status !== want.status)
        report($sformatf("status_out got %h want %h", got.status, want.status));
      if (got.taken !== want.taken)
        report($sformatf("branch_taken got %b want %b", got.taken, want.taken));
    end
  endtask
endclass

module tb_cpu8_alu_register_execute;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic no_stall = 1'b0;

  logic [7:0] corner_bytes [4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};

  cpu8_state_tracker tracker = new();

  c8alu_in_if  req_if();
  c8alu_out_if res_if();

  cpu8_alu_register_execute uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.action = 5'd0;
    req_if.operand = 8'h00;
    req_if.branch_cond = 3'd0;
    res_if.ready = 1'b0;
  end

  // result side: random backpressure, none during the no-stall stretch
  always @(negedge clk) begin
    if (rst_n)
      res_if.ready <= no_stall || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_result('{res_if.acc_out, res_if.x_out, res_if.y_out, res_if.sp_out,
                             res_if.status_out, res_if.branch_taken});
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [4:0] act, input logic [7:0] m,
                              input logic [2:0] cond);
    while (!no_stall && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.operand <= m;
    req_if.branch_cond <= cond;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tracker.note_request(act, m, cond);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(3) == 0)
      return corner_bytes[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [4:0] act;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every operation once with corner operands, then two undefined codes
    for (int k = 0; k < 28; k++) begin
      act = (k < 26) ? 5'(k) : ((k == 26) ? 5'd26 : 5'd31);
      send_request(act, corner_bytes[k % 4], 3'(k));
    end

    for (int n = 0; n < 1600; n++) begin
      no_stall = (n >= 600 && n < 900);
      if ($urandom_range(99) < 6)
        act = 5'($urandom_range(31, 26));
      else
        act = 5'($urandom_range(25));
      send_request(act, pick_operand(), 3'($urandom_range(7)));
    end
    no_stall = 1'b0;
    req_if.valid <= 1'b0;

    while (tracker.expected_regs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// File: files.f
rtl/c8alu_pkg.sv
rtl/c8alu_if.sv
rtl/cpu8_alu_register_execute.sv
tb/sv/tb_cpu8_alu_register_execute.sv
